/* rtl/plk_pkg.sv */
// ----------------------------------------------------------------------------
// plk_pkg: shared types and constants for the password entry lock
// Codes, key bytes, field widths and the structs passed between modules.
// ----------------------------------------------------------------------------
package plk_pkg;

	localparam int MAX_ENTRY = 16;
	localparam int CNT_W     = $clog2(MAX_ENTRY + 1);
	localparam int IDX_W     = (MAX_ENTRY > 1) ? $clog2(MAX_ENTRY) : 1;
	localparam int PW_BYTES  = 16;
	localparam int KEY_W     = 8;
	localparam int FAIL_W    = 8;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int TDATA_W   = 24;
	localparam int S_TDATA_W = 8;

	localparam logic [CFG_W-1:0] PW_LOW_RESET  = 64'h0000_0000_3433_3231;
	localparam logic [CFG_W-1:0] PW_HIGH_RESET = 64'h0;
	localparam logic [4:0]       PW_LEN_RESET  = 5'd4;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PW_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PW_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PW_LEN  = 2'd2;

	// Operation codes
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_LOCK = 1'b1;

	// Key bytes with a meaning
	localparam logic [KEY_W-1:0] KEY_BS    = 8'd8;
	localparam logic [KEY_W-1:0] KEY_LF    = 8'd10;
	localparam logic [KEY_W-1:0] KEY_CR    = 8'd13;
	localparam logic [KEY_W-1:0] KEY_SPACE = 8'd32;
	localparam logic [KEY_W-1:0] KEY_DEL   = 8'd127;

	localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

	typedef enum logic [2:0] {
		EV_IGNORED  = 3'd0,
		EV_APPENDED = 3'd1,
		EV_ERASED   = 3'd2,
		EV_UNLOCKED = 3'd3,
		EV_REJECTED = 3'd4,
		EV_LOCKED   = 3'd5
	} ev_t;

	typedef struct packed {
		logic             op;
		logic [KEY_W-1:0] key;
	} item_t;

	typedef struct packed {
		logic [8*PW_BYTES-1:0] chars;   // byte i in bits 8*i+7:8*i
		logic [4:0]            len;
	} cfg_t;

	// First field in the highest bits
	typedef struct packed {
		ev_t               event_code;
		logic [CNT_W-1:0]  entry_length;
		logic [FAIL_W-1:0] failure_count;
		logic              is_locked;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

/* rtl/plk_cfg_regs.sv */
// ----------------------------------------------------------------------------
// plk_cfg_regs: password configuration registers
// Holds password bytes and length; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module plk_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [plk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [plk_pkg::CFG_W-1:0]      cfg_data,
	output plk_pkg::cfg_t                  cfg
);
	import plk_pkg::*;

	logic [CFG_W-1:0] pw_low_q;
	logic [CFG_W-1:0] pw_high_q;
	logic [4:0]       pw_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_low_q  <= PW_LOW_RESET;
			pw_high_q <= PW_HIGH_RESET;
			pw_len_q  <= PW_LEN_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PW_LOW:  pw_low_q  <= cfg_data;
				REG_PW_HIGH: pw_high_q <= cfg_data;
				REG_PW_LEN:  pw_len_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign cfg.chars = {pw_high_q, pw_low_q};
	assign cfg.len   = pw_len_q;

endmodule

/* rtl/plk_in_stage.sv */
// ----------------------------------------------------------------------------
// plk_in_stage: input register
// Captures one item per transfer and holds it until the core advances.
// ----------------------------------------------------------------------------
module plk_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  plk_pkg::item_t in_item,
	input  logic           advance,
	output logic           valid_s1,
	output plk_pkg::item_t item_s1
);
	import plk_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* rtl/plk_core.sv */
// ----------------------------------------------------------------------------
// plk_core: lock state update and result register
// Applies one item per cycle to the lock state, unless the result register is stalled, and registers the result.
// ----------------------------------------------------------------------------
module plk_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  plk_pkg::item_t item_s1,
	input  plk_pkg::cfg_t  cfg,
	output logic           advance,
	output logic           out_valid,
	input  logic           out_ready,
	output plk_pkg::res_t  res_s2
);
	import plk_pkg::*;

	logic              locked_q;
	logic [CNT_W-1:0]  count_q;
	logic [FAIL_W-1:0] fail_q;
	logic [KEY_W-1:0]  entry_q [MAX_ENTRY];

	logic              locked_d;
	logic [CNT_W-1:0]  count_d;
	logic [FAIL_W-1:0] fail_d;
	ev_t               ev_d;
	logic              wr_en;
	logic [MAX_ENTRY-1:0] byte_ok;
	logic              match;
	logic              is_enter;
	logic              is_print;

	assign advance = valid_s1 && (!out_valid || out_ready);

	// Bytes at or above the entry count take no part in the compare
	always_comb begin
		for (int i = 0; i < MAX_ENTRY; i++) begin
			byte_ok[i] = (CNT_W'(i) >= count_q) ||
				(entry_q[i] == cfg.chars[8*i +: 8]);
		end
	end

	assign match    = (count_q == cfg.len) && (&byte_ok);
	assign is_enter = (item_s1.key == KEY_LF) || (item_s1.key == KEY_CR);
	assign is_print = (item_s1.key >= KEY_SPACE) && (item_s1.key < KEY_DEL);

	always_comb begin
		locked_d = locked_q;
		count_d  = count_q;
		fail_d   = fail_q;
		ev_d     = EV_IGNORED;
		wr_en    = 1'b0;
		priority if (item_s1.op == OP_LOCK) begin
			locked_d = 1'b1;
			count_d  = '0;
			ev_d     = EV_LOCKED;
		end else if (!locked_q) begin
			ev_d = EV_IGNORED;
		end else if (is_enter) begin
			if (match) begin
				locked_d = 1'b0;
				fail_d   = '0;
				ev_d     = EV_UNLOCKED;
			end else begin
				if (fail_q != FAIL_MAX) fail_d = fail_q + 1'b1;
				count_d = '0;
				ev_d    = EV_REJECTED;
			end
		end else if (item_s1.key == KEY_BS) begin
			if (count_q != '0) begin
				count_d = count_q - 1'b1;
				ev_d    = EV_ERASED;
			end
		end else if (is_print && (count_q < CNT_W'(MAX_ENTRY))) begin
			wr_en   = 1'b1;
			count_d = count_q + 1'b1;
			ev_d    = EV_APPENDED;
		end else begin
			ev_d = EV_IGNORED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q  <= 1'b0;
			count_q   <= '0;
			fail_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				locked_q <= locked_d;
				count_q  <= count_d;
				fail_q   <= fail_d;
			end
			if (!out_valid || out_ready) out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			entry_q[count_q[IDX_W-1:0]] <= item_s1.key;
		end
		if (advance) begin
			res_s2.is_locked     <= locked_d;
			res_s2.failure_count <= fail_d;
			res_s2.entry_length  <= count_d;
			res_s2.event_code    <= ev_d;
		end
	end

endmodule

/* rtl/password_entry_lock_top.sv */
// ----------------------------------------------------------------------------
// password_entry_lock_top: keypad password lock
// Stream in lock commands and key bytes, stream out lock status per item.
// ----------------------------------------------------------------------------
// Each input transfer carries a lock command (s_tuser = 1) or a key byte
// (s_tuser = 0, byte in s_tdata) and yields exactly one result transfer with
// the lock flag, failure count, entry length and an event code. A lock
// command locks and clears the entry; while locked, printable keys append
// (up to 16 bytes), backspace erases, and enter or carriage return compares
// the entry against the configured password in parallel over all 16 bytes.
// The block takes one item per clock cycle while the result stream is not
// stalled; the input register takes the item at the transfer, and the
// result register takes its result when the core advances, as the lock
// state is updated. The password registers reset to "1234" with length 4;
// write them only while the block has no item in flight.
module password_entry_lock_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [plk_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] key_code
	input  logic                               s_tuser,   // [0] operation
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] is_locked, [8:1] failure_count, [13:9] entry_length,
	// [16:14] event_code, [23:17] zero
	output logic [plk_pkg::TDATA_W-1:0]        m_tdata,
	input  logic                               cfg_wr_en,
	input  logic [plk_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [plk_pkg::CFG_W-1:0]          cfg_data
);
	import plk_pkg::*;

	item_t in_item;
	item_t item_s1;
	logic  valid_s1;
	logic  advance;
	cfg_t  cfg;
	res_t  res_s2;

	assign in_item.op  = s_tuser;
	assign in_item.key = s_tdata;

	plk_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Hold the incoming transfer until the core takes it
	plk_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Advance the lock state and register the result
	plk_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.cfg       (cfg),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_s2    (res_s2)
	);

	// Pad the packed result with zeros up to whole bytes
	assign m_tdata = {(TDATA_W - RES_W)'(0), res_s2};

endmodule

/* rtl/plk_checker.sv */
// ----------------------------------------------------------------------------
// plk_checker: port-level checks for the password entry lock
// Watches the result stream for stalls, consistent lock status, entry length range and zero padding.
// ----------------------------------------------------------------------------
module plk_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [plk_pkg::TDATA_W-1:0]   m_tdata
);
	import plk_pkg::*;

	res_t res;
	assign res = m_tdata[RES_W-1:0];

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_locked: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.event_code == EV_LOCKED) |->
			res.is_locked && (res.entry_length == '0))
		else $error("lock event without locked, empty entry");

	a_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.event_code == EV_UNLOCKED) |->
			!res.is_locked && (res.failure_count == '0))
		else $error("unlock event with wrong status");

	a_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.event_code == EV_REJECTED) |->
			res.is_locked && (res.entry_length == '0) && (res.failure_count != '0))
		else $error("reject event with wrong status");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.entry_length <= CNT_W'(MAX_ENTRY)) &&
			(m_tdata[TDATA_W-1:RES_W] == '0))
		else $error("entry length or padding out of range");

endmodule

bind password_entry_lock_top plk_checker u_plk_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
